FILE: rtl/circle_span_rasterizer_assert.svh
// Assertion macros shared by the circle span rasteriser modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef CIRCLE_SPAN_RASTERIZER_ASSERT_SVH
`define CIRCLE_SPAN_RASTERIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSR_ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circle span rasteriser: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circle span rasteriser: next-cycle check failed");

`endif

FILE: rtl/csrast_pkg.sv
// Shared types, constants and the span slot table of the circle span rasteriser.
// No dependencies.
package csrast_pkg;

  localparam int COORD_BITS_DEF   = 16;
  localparam int SURFACE_BITS_DEF = 13;
  localparam int REG_BITS         = 14;
  localparam int REG_INDEX_BITS   = 1;
  localparam int RADIUS_BITS      = 14;
  localparam int COLOUR_BITS      = 32;
  localparam int STEP_BITS        = 15;
  localparam int DEC_BITS         = 18;
  localparam int QUEUE_DEPTH      = 2;
  localparam int SLOT_BITS        = 4;

  localparam logic [REG_INDEX_BITS-1:0] REG_SURFACE_WIDTH  = 1'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_SURFACE_HEIGHT = 1'd1;

  localparam logic [REG_BITS-1:0] WIDTH_RESET  = 14'd640;
  localparam logic [REG_BITS-1:0] HEIGHT_RESET = 14'd480;

  localparam logic [DEC_BITS-1:0] DEC_START_BIAS = 18'd3;
  localparam logic [DEC_BITS-1:0] DEC_INC_BIAS   = 18'd6;
  localparam logic [DEC_BITS-1:0] DEC_DIAG_BIAS  = 18'd10;

  localparam logic [SLOT_BITS-1:0] SLOT_FIRST      = 4'd0;
  localparam logic [SLOT_BITS-1:0] SLOT_LAST_POINT = 4'd7;
  localparam logic [SLOT_BITS-1:0] SLOT_MARKER     = 4'd12;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_t;

  typedef enum logic [0:0] {
    KIND_SPAN   = 1'b0,
    KIND_MARKER = 1'b1
  } kind_t;

  // Control part of a job passed from the front end to the span sequencer.
  typedef struct packed {
    logic marker_only;
    logic more;
    logic fill;
  } job_ctl_t;

  // How a slot forms its row and columns from the center and the step offsets.
  typedef struct packed {
    logic row_y;
    logic row_neg;
    logic col_y;
    logic first_neg;
    logic last_neg;
  } slot_sel_t;

  // Slots 0 to 7 are the octant points, 8 to 11 the fill spans.
  function automatic slot_sel_t slot_select(input logic [SLOT_BITS-1:0] slot);
    slot_sel_t s;
    case (slot)
      4'd0:    s = '{row_y: 1'b1, row_neg: 1'b0, col_y: 1'b0, first_neg: 1'b0, last_neg: 1'b0};
      4'd1:    s = '{row_y: 1'b0, row_neg: 1'b0, col_y: 1'b1, first_neg: 1'b0, last_neg: 1'b0};
      4'd2:    s = '{row_y: 1'b1, row_neg: 1'b0, col_y: 1'b0, first_neg: 1'b1, last_neg: 1'b1};
      4'd3:    s = '{row_y: 1'b0, row_neg: 1'b1, col_y: 1'b1, first_neg: 1'b0, last_neg: 1'b0};
      4'd4:    s = '{row_y: 1'b1, row_neg: 1'b1, col_y: 1'b0, first_neg: 1'b1, last_neg: 1'b1};
      4'd5:    s = '{row_y: 1'b0, row_neg: 1'b1, col_y: 1'b1, first_neg: 1'b1, last_neg: 1'b1};
      4'd6:    s = '{row_y: 1'b1, row_neg: 1'b1, col_y: 1'b0, first_neg: 1'b0, last_neg: 1'b0};
      4'd7:    s = '{row_y: 1'b0, row_neg: 1'b0, col_y: 1'b1, first_neg: 1'b1, last_neg: 1'b1};
      4'd8:    s = '{row_y: 1'b1, row_neg: 1'b0, col_y: 1'b0, first_neg: 1'b1, last_neg: 1'b0};
      4'd9:    s = '{row_y: 1'b1, row_neg: 1'b1, col_y: 1'b0, first_neg: 1'b1, last_neg: 1'b0};
      4'd10:   s = '{row_y: 1'b0, row_neg: 1'b0, col_y: 1'b1, first_neg: 1'b1, last_neg: 1'b0};
      4'd11:   s = '{row_y: 1'b0, row_neg: 1'b1, col_y: 1'b1, first_neg: 1'b1, last_neg: 1'b0};
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/csrast_front.sv
// Front end: accepts transactions, holds the circle state and the decision variable.
// Depends on csrast_pkg and the assertion macro header.
`include "circle_span_rasterizer_assert.svh"

module csrast_front #(
  parameter int COORD_BITS = csrast_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    opcode,
  input  logic signed [COORD_BITS-1:0]            center_x,
  input  logic signed [COORD_BITS-1:0]            center_y,
  input  logic [csrast_pkg::RADIUS_BITS-1:0]      radius,
  input  logic [csrast_pkg::COLOUR_BITS-1:0]      colour,
  input  logic                                    filled,
  input  logic                                    q_full,
  output logic                                    push,
  output csrast_pkg::job_ctl_t                    job_ctl,
  output logic signed [COORD_BITS-1:0]            job_cx,
  output logic signed [COORD_BITS-1:0]            job_cy,
  output logic [csrast_pkg::STEP_BITS-1:0]        job_x,
  output logic signed [csrast_pkg::STEP_BITS-1:0] job_y,
  output logic [csrast_pkg::COLOUR_BITS-1:0]      job_colour
);
  import csrast_pkg::*;

  logic                          active;
  logic [STEP_BITS-1:0]          step_x;
  logic signed [STEP_BITS-1:0]   step_y;
  logic [DEC_BITS-1:0]           decision;
  logic signed [COORD_BITS-1:0]  held_center_x;
  logic signed [COORD_BITS-1:0]  held_center_y;
  logic [COLOUR_BITS-1:0]        held_colour;
  logic                          held_fill;

  logic                          step_ok;
  logic                          is_start;
  logic [DEC_BITS-1:0]           x_ext;
  logic [DEC_BITS-1:0]           y_ext;
  logic [DEC_BITS-1:0]           decision_step;
  logic [DEC_BITS-1:0]           decision_start;
  logic [STEP_BITS-1:0]          x_after;
  logic signed [STEP_BITS-1:0]   y_after;
  logic                          more_after;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign is_start = (opcode == OP_START);

  assign step_ok = active &&
                   ($signed({1'b0, step_x}) <= $signed({step_y[STEP_BITS-1], step_y}));

  assign x_ext = {{(DEC_BITS-STEP_BITS){1'b0}}, step_x};
  assign y_ext = {{(DEC_BITS-STEP_BITS){step_y[STEP_BITS-1]}}, step_y};

  // A negative decision keeps y; otherwise the step moves diagonally and y drops by one.
  always_comb begin
    if (decision[DEC_BITS-1]) begin
      decision_step = decision + (x_ext << 2) + DEC_INC_BIAS;
      y_after       = step_y;
    end else begin
      decision_step = decision + ((x_ext - y_ext) << 2) + DEC_DIAG_BIAS;
      y_after       = step_y - 1'b1;
    end
  end

  assign x_after        = step_x + 1'b1;
  assign more_after     = $signed({1'b0, x_after}) <= $signed({y_after[STEP_BITS-1], y_after});
  assign decision_start = DEC_START_BIAS - ({{(DEC_BITS-RADIUS_BITS){1'b0}}, radius} << 1);

  always_comb begin
    job_ctl.marker_only = 1'b1;
    job_ctl.more        = 1'b0;
    job_ctl.fill        = held_fill;
    if (is_start) begin
      job_ctl.more = 1'b1;
    end else if (step_ok) begin
      job_ctl.marker_only = 1'b0;
      job_ctl.more        = more_after;
    end
  end

  assign job_cx     = held_center_x;
  assign job_cy     = held_center_y;
  assign job_x      = step_x;
  assign job_y      = step_y;
  assign job_colour = held_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      step_x        <= '0;
      step_y        <= '0;
      decision      <= '0;
      held_center_x <= '0;
      held_center_y <= '0;
      held_colour   <= '0;
      held_fill     <= 1'b0;
    end else if (push) begin
      if (is_start) begin
        active        <= 1'b1;
        step_x        <= '0;
        step_y        <= $signed({{(STEP_BITS-RADIUS_BITS){1'b0}}, radius});
        decision      <= decision_start;
        held_center_x <= center_x;
        held_center_y <= center_y;
        held_colour   <= colour;
        held_fill     <= filled;
      end else if (step_ok) begin
        step_x   <= x_after;
        step_y   <= y_after;
        decision <= decision_step;
      end
    end
  end

  `CSR_ASSERT_NEXT(a_start_loads, push && is_start, active && step_x == '0)
  `CSR_ASSERT_NEXT(a_step_advances, push && !is_start && step_ok, step_x == $past(step_x) + 1'b1)

endmodule

FILE: rtl/csrast_queue.sv
// Short job queue between the front end and the span sequencer.
// Depends on csrast_pkg and the assertion macro header.
`include "circle_span_rasterizer_assert.svh"

module csrast_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data,
  output logic             full
);
  import csrast_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

  logic [WIDTH-1:0]    entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign head_valid = (count != '0);
  assign full       = (count == CNT_FULL);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CSR_ASSERT_HOLDS(a_count_bound, 1'b1, count <= CNT_FULL)
  `CSR_ASSERT_HOLDS(a_pop_needs_entry, pop, head_valid)
  `CSR_ASSERT_NEXT(a_pop_drains, pop && !push, count == $past(count) - 1'b1)

endmodule

FILE: rtl/csrast_back.sv
// Span sequencer: walks up to twelve span slots of a job, clips them and drives
// the output register. Depends on csrast_pkg and the assertion macro header.
`include "circle_span_rasterizer_assert.svh"

module csrast_back #(
  parameter int COORD_BITS   = csrast_pkg::COORD_BITS_DEF,
  parameter int SURFACE_BITS = csrast_pkg::SURFACE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    head_valid,
  input  csrast_pkg::job_ctl_t                    head_ctl,
  input  logic signed [COORD_BITS-1:0]            head_cx,
  input  logic signed [COORD_BITS-1:0]            head_cy,
  input  logic [csrast_pkg::STEP_BITS-1:0]        head_x,
  input  logic signed [csrast_pkg::STEP_BITS-1:0] head_y,
  input  logic [csrast_pkg::COLOUR_BITS-1:0]      head_colour,
  input  logic [SURFACE_BITS:0]                   lim_w,
  input  logic [SURFACE_BITS:0]                   lim_h,
  output logic                                    pop,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    kind,
  output logic [SURFACE_BITS-1:0]                 row,
  output logic [SURFACE_BITS-1:0]                 col_first,
  output logic [SURFACE_BITS-1:0]                 col_last,
  output logic [csrast_pkg::COLOUR_BITS-1:0]      pixel_value,
  output logic                                    more_steps
);
  import csrast_pkg::*;

  // Wide enough for center plus offset and for the surface limit, with sign.
  localparam int EA = (COORD_BITS > STEP_BITS + 1) ? COORD_BITS : STEP_BITS + 1;
  localparam int EW = (EA + 1 > SURFACE_BITS + 2) ? EA + 1 : SURFACE_BITS + 2;

  logic [SLOT_BITS-1:0] slot;
  logic [SLOT_BITS-1:0] slot_eff;
  slot_sel_t            sel;
  logic                 is_marker;
  logic                 out_free;
  logic                 emit;
  logic                 advance;

  logic signed [EW-1:0] cx_e;
  logic signed [EW-1:0] cy_e;
  logic signed [EW-1:0] x_e;
  logic signed [EW-1:0] y_e;
  logic signed [EW-1:0] row_off;
  logic signed [EW-1:0] col_off;
  logic signed [EW-1:0] row_v;
  logic signed [EW-1:0] first_v;
  logic signed [EW-1:0] last_v;
  logic signed [EW-1:0] h_e;
  logic signed [EW-1:0] w_last;
  logic signed [EW-1:0] first_c;
  logic signed [EW-1:0] last_c;
  logic                 drop;

  assign slot_eff  = head_ctl.marker_only ? SLOT_MARKER : slot;
  assign is_marker = (slot_eff == SLOT_MARKER);
  assign sel       = slot_select(slot_eff);

  assign cx_e = {{(EW-COORD_BITS){head_cx[COORD_BITS-1]}}, head_cx};
  assign cy_e = {{(EW-COORD_BITS){head_cy[COORD_BITS-1]}}, head_cy};
  assign x_e  = {{(EW-STEP_BITS){1'b0}}, head_x};
  assign y_e  = {{(EW-STEP_BITS){head_y[STEP_BITS-1]}}, head_y};

  assign row_off = sel.row_y ? y_e : x_e;
  assign col_off = sel.col_y ? y_e : x_e;
  assign row_v   = sel.row_neg ? cy_e - row_off : cy_e + row_off;
  assign first_v = sel.first_neg ? cx_e - col_off : cx_e + col_off;
  assign last_v  = sel.last_neg ? cx_e - col_off : cx_e + col_off;

  assign h_e    = {{(EW-SURFACE_BITS-1){1'b0}}, lim_h};
  assign w_last = {{(EW-SURFACE_BITS-1){1'b0}}, lim_w} - 1'b1;

  // Clamp the columns to the surface; a span left empty, or off the rows, is dropped.
  assign first_c = (first_v < 0) ? '0 : first_v;
  assign last_c  = (last_v > w_last) ? w_last : last_v;
  assign drop    = (row_v < 0) || (row_v >= h_e) || (first_c > last_c);

  assign out_free = !out_valid || !out_stall;
  assign emit     = head_valid && (is_marker || !drop);
  assign advance  = head_valid && (!emit || out_free);
  assign pop      = advance && is_marker;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= SLOT_FIRST;
    end else if (advance) begin
      if (is_marker) begin
        slot <= SLOT_FIRST;
      end else if (slot == SLOT_LAST_POINT && !head_ctl.fill) begin
        slot <= SLOT_MARKER;
      end else begin
        slot <= slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_free) begin
      if (is_marker) begin
        kind        <= KIND_MARKER;
        row         <= '0;
        col_first   <= '0;
        col_last    <= '0;
        pixel_value <= '0;
        more_steps  <= head_ctl.more;
      end else begin
        kind        <= KIND_SPAN;
        row         <= row_v[SURFACE_BITS-1:0];
        col_first   <= first_c[SURFACE_BITS-1:0];
        col_last    <= last_c[SURFACE_BITS-1:0];
        pixel_value <= head_colour;
        more_steps  <= 1'b0;
      end
    end
  end

  `CSR_ASSERT_HOLDS(a_slot_range, 1'b1, slot <= SLOT_MARKER)
  `CSR_ASSERT_HOLDS(a_marker_job_slot, head_valid && head_ctl.marker_only, slot == SLOT_FIRST)
  `CSR_ASSERT_HOLDS(a_span_no_more, out_valid && kind == KIND_SPAN, !more_steps)

endmodule

FILE: rtl/circle_span_rasterizer.sv
// Top level of the circle span rasteriser: surface registers, front end, job queue
// and span sequencer. Depends on csrast_pkg, csrast_front, csrast_queue, csrast_back.
//
//   Channel  Direction  Handshake            Fields
//   in       input      in_valid/in_stall    opcode center_x center_y radius colour filled
//   out      output     out_valid/out_stall  kind row col_first col_last pixel_value more_steps
//   cfg      input      cfg_write            cfg_index cfg_data
//
// Without fill the sequencer walks the eight point slots, with fill all twelve; a start or an
// exhausted step gives only the marker. It visits one slot per cycle, clipped ones included,
// unless the output stalls, and ends with the marker. Reset clears the circle state and sets
// the surface to 640 by 480; there is no clearing pass. A stalled output holds the output
// register; the two-entry job queue lets the front end take transactions until full.
module circle_span_rasterizer #(
  parameter int COORD_BITS   = csrast_pkg::COORD_BITS_DEF,
  parameter int SURFACE_BITS = csrast_pkg::SURFACE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_write,
  input  logic [csrast_pkg::REG_INDEX_BITS-1:0]     cfg_index,
  input  logic [csrast_pkg::REG_BITS-1:0]           cfg_data,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic                                      opcode,
  input  logic signed [COORD_BITS-1:0]              center_x,
  input  logic signed [COORD_BITS-1:0]              center_y,
  input  logic [csrast_pkg::RADIUS_BITS-1:0]        radius,
  input  logic [csrast_pkg::COLOUR_BITS-1:0]        colour,
  input  logic                                      filled,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic                                      kind,
  output logic [SURFACE_BITS-1:0]                   row,
  output logic [SURFACE_BITS-1:0]                   col_first,
  output logic [SURFACE_BITS-1:0]                   col_last,
  output logic [csrast_pkg::COLOUR_BITS-1:0]        pixel_value,
  output logic                                      more_steps
);
  import csrast_pkg::*;

  localparam int JOB_W = $bits(job_ctl_t) + 2 * COORD_BITS + 2 * STEP_BITS + COLOUR_BITS;
  localparam int LIM_BITS = SURFACE_BITS + 1;
  localparam logic [31:0] SURF_CAP = 32'd1 << SURFACE_BITS;

  logic [REG_BITS-1:0] surface_width;
  logic [REG_BITS-1:0] surface_height;
  logic [LIM_BITS-1:0] lim_w;
  logic [LIM_BITS-1:0] lim_h;

  logic                          push;
  logic                          pop;
  logic                          q_full;
  logic                          head_valid;
  logic [JOB_W-1:0]              push_data;
  logic [JOB_W-1:0]              head_data;

  job_ctl_t                      job_ctl;
  logic signed [COORD_BITS-1:0]  job_cx;
  logic signed [COORD_BITS-1:0]  job_cy;
  logic [STEP_BITS-1:0]          job_x;
  logic signed [STEP_BITS-1:0]   job_y;
  logic [COLOUR_BITS-1:0]        job_colour;

  job_ctl_t                      head_ctl;
  logic signed [COORD_BITS-1:0]  head_cx;
  logic signed [COORD_BITS-1:0]  head_cy;
  logic [STEP_BITS-1:0]          head_x;
  logic signed [STEP_BITS-1:0]   head_y;
  logic [COLOUR_BITS-1:0]        head_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= WIDTH_RESET;
      surface_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SURFACE_WIDTH:  surface_width  <= cfg_data;
        REG_SURFACE_HEIGHT: surface_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Register values beyond the addressable surface are capped so every output fits.
  assign lim_w = (32'(surface_width) > SURF_CAP) ? LIM_BITS'(SURF_CAP)
                                                 : LIM_BITS'(surface_width);
  assign lim_h = (32'(surface_height) > SURF_CAP) ? LIM_BITS'(SURF_CAP)
                                                  : LIM_BITS'(surface_height);

  csrast_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius     (radius),
    .colour     (colour),
    .filled     (filled),
    .q_full     (q_full),
    .push       (push),
    .job_ctl    (job_ctl),
    .job_cx     (job_cx),
    .job_cy     (job_cy),
    .job_x      (job_x),
    .job_y      (job_y),
    .job_colour (job_colour)
  );

  assign push_data = {job_ctl, job_cx, job_cy, job_x, job_y, job_colour};
  assign {head_ctl, head_cx, head_cy, head_x, head_y, head_colour} = head_data;

  csrast_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .full       (q_full)
  );

  csrast_back #(
    .COORD_BITS   (COORD_BITS),
    .SURFACE_BITS (SURFACE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_ctl    (head_ctl),
    .head_cx     (head_cx),
    .head_cy     (head_cy),
    .head_x      (head_x),
    .head_y      (head_y),
    .head_colour (head_colour),
    .lim_w       (lim_w),
    .lim_h       (lim_h),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .row         (row),
    .col_first   (col_first),
    .col_last    (col_last),
    .pixel_value (pixel_value),
    .more_steps  (more_steps)
  );

endmodule
